### src/sia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sia_pkg
// Shared widths, operation kinds and status codes of the slot id allocator.
// ---------------------------------------------------------------------------
package sia_pkg;

    localparam int ID_W     = 8;
    localparam int CNT_W    = ID_W + 1;
    localparam int PRIO_W   = 16;
    localparam int ID_SPACE = 2 ** ID_W;

    localparam int POOL_SIZE  = 256;
    localparam int POOL_LIMIT = (POOL_SIZE < ID_SPACE) ? POOL_SIZE : ID_SPACE;

    typedef logic [1:0]        t_kind;
    typedef logic [1:0]        t_status;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [PRIO_W-1:0] t_prio;

    localparam t_kind KIND_ALLOC   = 2'd0;
    localparam t_kind KIND_FREE    = 2'd1;
    localparam t_kind KIND_COMPACT = 2'd2;
    localparam t_kind KIND_CLEAR   = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;
    localparam t_status ST_FREED = 2'd3;

endpackage

`default_nettype wire

### src/slot_id_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Slot id allocator. One request is taken at a time; o_in_ready is high only
// while the sequencer is idle. Free and clear all go from the execute state
// to the output state, as does an allocate that grows the span; an allocate
// from the free stack passes the pop state between them, since the stack
// memory gives registered read data. Compact passes the trim state, which
// drops free ids off the top of the span, then the scan state, in which the
// valid bits are walked one id a cycle and the free stack is rewritten in
// ascending order. A finished result sits in an output register, so the next
// request may be taken while it waits; there is no clearing pass after reset.
// ---------------------------------------------------------------------------
// slot_id_allocator
// Hands out slot ids from a free stack or by growing the span, releases them,
// compacts the free stack and clears all, under a small sequencer.
// ---------------------------------------------------------------------------
module slot_id_allocator (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  sia_pkg::t_kind  i_kind,
    input  wire  sia_pkg::t_id    i_slot,
    input  wire  sia_pkg::t_prio  i_priority_req,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [7:0]            o_granted_slot,
    output logic [1:0]            o_status,
    output logic [8:0]            o_span,
    output logic [8:0]            o_free_count
);
    import sia_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_TRIM = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam t_cnt LIMIT = CNT_W'(POOL_LIMIT);

    logic [2:0]          r_state, n_state;
    t_kind               r_kind, n_kind;
    t_id                 r_slot, n_slot;
    t_prio               r_prio, n_prio;
    t_cnt                r_span, n_span;
    t_cnt                r_depth, n_depth;
    t_cnt                r_idx, n_idx;
    t_cnt                r_wp, n_wp;
    logic [ID_SPACE-1:0] r_valid, n_valid;
    t_id                 r_granted, n_granted;
    t_status             r_status, n_status;

    logic                r_out_valid, n_out_valid;
    t_id                 r_o_granted, n_o_granted;
    t_status             r_o_status, n_o_status;
    t_cnt                r_o_span, n_o_span;
    t_cnt                r_o_depth, n_o_depth;

    // free stack and priority stores
    t_id   stack_mem [ID_SPACE];
    t_prio prio_mem  [ID_SPACE];
    t_id   r_rd_data;

    logic  stk_we, stk_re, pri_we;
    t_id   stk_wa, stk_wd, stk_ra, pri_wa;
    t_cnt  span_m1;

    assign span_m1    = r_span - 1'b1;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_prio      = r_prio;
        n_span      = r_span;
        n_depth     = r_depth;
        n_idx       = r_idx;
        n_wp        = r_wp;
        n_valid     = r_valid;
        n_granted   = r_granted;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_granted = r_o_granted;
        n_o_status  = r_o_status;
        n_o_span    = r_o_span;
        n_o_depth   = r_o_depth;
        stk_we      = 1'b0;
        stk_wa      = r_wp[ID_W-1:0];
        stk_wd      = r_idx[ID_W-1:0];
        stk_re      = 1'b0;
        stk_ra      = span_m1[ID_W-1:0];
        pri_we      = 1'b0;
        pri_wa      = r_span[ID_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind    = i_kind;
                    n_slot    = i_slot;
                    n_prio    = i_priority_req;
                    n_granted = '0;
                    n_status  = ST_OK;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_kind)
                    KIND_ALLOC: begin
                        if (r_depth != '0) begin
                            stk_re  = 1'b1;
                            stk_ra  = t_id'(r_depth - 1'b1);
                            n_depth = r_depth - 1'b1;
                            n_state = S_POP;
                        end else if (r_span < LIMIT) begin
                            n_valid[r_span[ID_W-1:0]] = 1'b1;
                            pri_we    = 1'b1;
                            pri_wa    = r_span[ID_W-1:0];
                            n_granted = r_span[ID_W-1:0];
                            n_span    = r_span + 1'b1;
                            n_state   = S_OUT;
                        end else begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end
                    end
                    KIND_FREE: begin
                        n_state = S_OUT;
                        if ({1'b0, r_slot} >= r_span) begin
                            n_status = ST_RANGE;
                        end else if (!r_valid[r_slot]) begin
                            n_status = ST_FREED;
                        end else begin
                            n_valid[r_slot] = 1'b0;
                            if ({1'b0, r_slot} == span_m1) begin
                                n_span = span_m1;
                            end else if (!r_depth[CNT_W-1]) begin
                                // push the id; a push onto a full stack is dropped
                                stk_we  = 1'b1;
                                stk_wa  = r_depth[ID_W-1:0];
                                stk_wd  = r_slot;
                                n_depth = r_depth + 1'b1;
                            end
                        end
                    end
                    KIND_COMPACT: begin
                        n_state = S_TRIM;
                    end
                    default: begin
                        n_span  = '0;
                        n_depth = '0;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_POP: begin
                n_valid[r_rd_data] = 1'b1;
                pri_we    = 1'b1;
                pri_wa    = r_rd_data;
                n_granted = r_rd_data;
                n_state   = S_OUT;
            end
            S_TRIM: begin
                // drop free ids off the top of the span one at a time
                if (r_span != '0 && r_depth != '0 && !r_valid[span_m1[ID_W-1:0]]) begin
                    n_span  = span_m1;
                    n_depth = r_depth - 1'b1;
                end else begin
                    n_idx   = '0;
                    n_wp    = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // rebuild the stack in ascending order from the valid bits
                if (r_idx == r_span) begin
                    n_state = S_OUT;
                end else begin
                    if (!r_valid[r_idx[ID_W-1:0]]) begin
                        stk_we = 1'b1;
                        stk_wa = r_wp[ID_W-1:0];
                        stk_wd = r_idx[ID_W-1:0];
                        n_wp   = r_wp + 1'b1;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_granted = r_granted;
                    n_o_status  = r_status;
                    n_o_span    = r_span;
                    n_o_depth   = r_depth;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_span      <= '0;
            r_depth     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_span      <= n_span;
            r_depth     <= n_depth;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_slot      <= n_slot;
        r_prio      <= n_prio;
        r_idx       <= n_idx;
        r_wp        <= n_wp;
        r_granted   <= n_granted;
        r_status    <= n_status;
        r_o_granted <= n_o_granted;
        r_o_status  <= n_o_status;
        r_o_span    <= n_o_span;
        r_o_depth   <= n_o_depth;
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stack_mem[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_rd_data <= stack_mem[stk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pri_we) begin
            prio_mem[pri_wa] <= r_prio;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted_slot = r_o_granted;
    assign o_status       = r_o_status;
    assign o_span         = r_o_span;
    assign o_free_count   = r_o_depth;

    a_span_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_span <= LIMIT)
        else $error("span beyond pool limit");

    a_depth_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_span)
        else $error("free stack deeper than span");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_kind == KIND_CLEAR) |-> (r_span == '0 && r_depth == '0))
        else $error("clear all left state behind");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_span == LIMIT && o_free_count == '0))
        else $error("pool full reported with room left");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted_slot != '0) |-> (o_status == ST_OK))
        else $error("slot granted with error status");

endmodule

`default_nettype wire

### tb/slot_id_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slot_id_checker
// Watches both channels of the slot id allocator, predicts each result from
// its own copy of the free stack, span and valid bits, and compares every
// returned result field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module slot_id_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  wire  sia_pkg::t_kind i_kind,
    input  wire  sia_pkg::t_id   i_slot,
    input  wire  sia_pkg::t_prio i_priority_req,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  wire  [7:0]           i_granted_slot,
    input  wire  [1:0]           i_status,
    input  wire  [8:0]           i_span,
    input  wire  [8:0]           i_free_count,
    output int                   o_fail_count,
    output int                   o_pending
);
    import sia_pkg::*;

    typedef struct packed {
        t_id     granted;
        t_status status;
        t_cnt    span;
        t_cnt    free_cnt;
    } t_slot_result;

    // Mirror of the allocator state
    t_id   free_ids[ID_SPACE];
    t_cnt  free_depth;
    t_cnt  used_span;
    bit    held[ID_SPACE];
    t_prio slot_prio[ID_SPACE];

    t_slot_result result_q[$];
    int           mismatches = 0;

    function automatic t_slot_result allocator_step(t_kind kind, t_id slot, t_prio prio);
        t_slot_result res;
        t_id          id;
        t_id          sorted_ids[$];
        res.granted = '0;
        res.status  = ST_OK;
        case (kind)
            KIND_ALLOC: begin
                if (free_depth != 0) begin
                    free_depth = free_depth - 1'b1;
                    id = free_ids[free_depth[ID_W-1:0]];
                end else if (used_span < POOL_LIMIT) begin
                    id = used_span[ID_W-1:0];
                    used_span = used_span + 1'b1;
                end else begin
                    res.status = ST_FULL;
                end
                if (res.status == ST_OK) begin
                    held[id]      = 1'b1;
                    slot_prio[id] = prio;
                    res.granted   = id;
                end
            end
            KIND_FREE: begin
                if ({1'b0, slot} >= used_span) begin
                    res.status = ST_RANGE;
                end else if (!held[slot]) begin
                    res.status = ST_FREED;
                end else begin
                    held[slot] = 1'b0;
                    if ({1'b0, slot} + 1 == used_span) begin
                        used_span = used_span - 1'b1;
                    end else if (free_depth < ID_SPACE) begin
                        free_ids[free_depth[ID_W-1:0]] = slot;
                        free_depth = free_depth + 1'b1;
                    end
                end
            end
            KIND_COMPACT: begin
                for (int i = 0; i < free_depth; i++)
                    sorted_ids.insert(sorted_ids.size(), free_ids[i]);
                sorted_ids.sort();
                foreach (sorted_ids[i])
                    free_ids[i] = sorted_ids[i];
                // Trim ids that sit right under the span
                while (free_depth != 0 && used_span != 0 &&
                       {1'b0, free_ids[(free_depth - 1) & (ID_SPACE - 1)]} == used_span - 1) begin
                    free_depth = free_depth - 1'b1;
                    used_span  = used_span - 1'b1;
                end
            end
            default: begin
                used_span  = '0;
                free_depth = '0;
            end
        endcase
        res.span     = used_span;
        res.free_cnt = free_depth;
        return res;
    endfunction

    function automatic int field_ok(string name, int exp_v, int act_v);
        if (exp_v == act_v)
            return 1;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_slot_result exp_r;
        int           ok;
        if (!i_rst_n) begin
            free_depth = '0;
            used_span  = '0;
            foreach (held[i])
                held[i] = 1'b0;
            result_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result with none expected, actual slot %0d status %0d span %0d free %0d",
                             $time, i_granted_slot, i_status, i_span, i_free_count);
                    mismatches++;
                end else begin
                    exp_r = result_q.pop_front();
                    ok  = field_ok("granted_slot", int'(exp_r.granted), int'(i_granted_slot));
                    ok &= field_ok("status", int'(exp_r.status), int'(i_status));
                    ok &= field_ok("span", int'(exp_r.span), int'(i_span));
                    ok &= field_ok("free_count", int'(exp_r.free_cnt), int'(i_free_count));
                    if (!ok)
                        mismatches++;
                end
            end
            if (i_in_valid && i_in_ready)
                result_q.insert(result_q.size(),
                                allocator_step(i_kind, i_slot, i_priority_req));
        end
        o_pending    <= result_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/slot_id_allocator_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slot_id_allocator_test
// Drives directed and random allocate, free, compact and clear requests into
// the slot id allocator with bursty requests and a stalling receiver; the
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module slot_id_allocator_test;
    import sia_pkg::*;

    logic  i_clk          = 1'b0;
    logic  i_rst_n        = 1'b0;
    logic  in_valid       = 1'b0;
    t_kind kind           = KIND_ALLOC;
    t_id   slot           = '0;
    t_prio priority_req   = '0;
    logic  out_ready      = 1'b0;

    logic       in_ready;
    logic       out_valid;
    logic [7:0] granted_slot;
    logic [1:0] status;
    logic [8:0] span;
    logic [8:0] free_count;

    int fail_count;
    int pending;

    int burst_left = 0;
    int span_guess = 0;
    int n_items    = 0;

    slot_id_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (kind),
        .i_slot         (slot),
        .i_priority_req (priority_req),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_granted_slot (granted_slot),
        .o_status       (status),
        .o_span         (span),
        .o_free_count   (free_count)
    );

    slot_id_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_kind         (kind),
        .i_slot         (slot),
        .i_priority_req (priority_req),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_granted_slot (granted_slot),
        .i_status       (status),
        .i_span         (span),
        .i_free_count   (free_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL slot_id_allocator");
        $finish;
    end

    // Receiver: stretches of always ready, random stalls and long stalls
    int ready_mode = 0;
    int ready_left = 0;
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(10, 60);
        end
        ready_left--;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_item(input t_kind k, input t_id s, input t_prio p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        kind         <= k;
        slot         <= s;
        priority_req <= p;
        do @(posedge i_clk); while (!in_ready);
        n_items++;
    endtask

    // Keep a rough view of the span so most frees land inside it
    task automatic issue_op(input t_kind k);
        t_id s;
        int  r;
        r = $urandom_range(0, 99);
        if (span_guess == 0 || r >= 85)
            s = t_id'($urandom_range(0, 255));
        else if (r < 70)
            s = t_id'($urandom_range(0, span_guess - 1));
        else
            s = t_id'(span_guess - 1);
        case (k)
            KIND_ALLOC: if (span_guess < POOL_LIMIT) span_guess++;
            KIND_FREE:  if (span_guess > 0 && s == span_guess - 1) span_guess--;
            KIND_CLEAR: span_guess = 0;
            default: ;
        endcase
        send_item(k, s, t_prio'($urandom_range(0, 16'hFFFF)));
    endtask

    initial begin
        int r;
        int mode;
        int len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, stack pops, span shrink, trim on compact
        send_item(KIND_ALLOC, 8'h00, 16'h0000);
        send_item(KIND_ALLOC, 8'hFF, 16'hFFFF);
        send_item(KIND_ALLOC, 8'hA5, 16'h5A5A);
        send_item(KIND_FREE, 8'hFF, 16'hFFFF);
        send_item(KIND_FREE, 8'h00, 16'h0000);
        send_item(KIND_FREE, 8'h00, 16'h0000);
        send_item(KIND_ALLOC, 8'h00, 16'h1234);
        send_item(KIND_FREE, 8'h02, 16'h0000);
        send_item(KIND_FREE, 8'h01, 16'h0000);
        send_item(KIND_CLEAR, 8'hFF, 16'hFFFF);
        send_item(KIND_FREE, 8'h00, 16'h0000);
        send_item(KIND_COMPACT, 8'h00, 16'h0000);
        repeat (4) send_item(KIND_ALLOC, 8'h00, t_prio'($urandom_range(0, 16'hFFFF)));
        send_item(KIND_FREE, 8'h01, 16'h0000);
        send_item(KIND_FREE, 8'h02, 16'h0000);
        send_item(KIND_COMPACT, 8'h00, 16'h0000);
        send_item(KIND_FREE, 8'h03, 16'h0000);
        send_item(KIND_COMPACT, 8'h00, 16'h0000);
        send_item(KIND_ALLOC, 8'h00, 16'hFFFF);
        send_item(KIND_CLEAR, 8'h00, 16'h0000);
        span_guess = 0;

        // Fill the pool past its limit
        repeat (300) begin
            r = $urandom_range(0, 99);
            issue_op((r < 94) ? KIND_ALLOC : KIND_FREE);
        end

        // Mixed phases: churn, drain towards empty, regrowth
        while (n_items < 800) begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(20, 80);
            repeat (len) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: issue_op(r < 50 ? KIND_ALLOC : r < 92 ? KIND_FREE :
                                r < 98 ? KIND_COMPACT : KIND_CLEAR);
                    1: issue_op(r < 15 ? KIND_ALLOC : r < 87 ? KIND_FREE :
                                r < 98 ? KIND_COMPACT : KIND_CLEAR);
                    default: issue_op(r < 75 ? KIND_ALLOC : r < 95 ? KIND_FREE :
                                      KIND_COMPACT);
                endcase
            end
        end
        in_valid <= 1'b0;

        // let the count from the last transfer settle before waiting on it
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS slot_id_allocator");
        else
            $display("FAIL slot_id_allocator");
        $finish;
    end

endmodule

### sim.f
src/sia_pkg.sv
src/slot_id_allocator.sv
tb/slot_id_checker.sv
tb/slot_id_allocator_test.sv
